[rtl/core/glsd_pkg.sv]
// Shared constants for the grid layout selection decoder.
// Field widths, default grid geometry and cell-centre spacing.
package glsd_pkg;

	localparam int GRID_CELLS_DEF   = 100;
	localparam int GRID_COLUMNS_DEF = 10;

	localparam int CHOICE_W = 8;
	localparam int CELL_W   = 7;
	localparam int METRE_W  = 11;

	localparam int CELL_PITCH_M  = 200;
	localparam int CELL_OFFSET_M = 100;

endpackage

[rtl/core/grid_layout_selection_decoder_top.sv]
// Grid layout selection decoder: maps design variables to turbine grid cells.
// Fixed-count picks come from a remaining-cell list in one synchronous RAM.
// An item that emits nothing is taken without leaving idle; a free-mode result
// passes through S_COORD and S_EMIT; a fixed-count result first waits for the
// list compaction in S_PICK and S_SHIFT, which moves one RAM entry per cycle.
// Reset: list, count, position and mode clear at once; no sweep of the RAM.
module grid_layout_selection_decoder_top
	import glsd_pkg::*;
#(
	parameter int GRID_CELLS   = GRID_CELLS_DEF,
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [CHOICE_W-1:0] choice,
	input  logic                       start_of_layout,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [CELL_W-1:0]          cell_index,
	output logic [METRE_W-1:0]         x_metres,
	output logic [METRE_W-1:0]         y_metres
);

	localparam int IDX_W  = $clog2(GRID_CELLS);
	localparam int CNT_W  = $clog2(GRID_CELLS + 1);
	localparam int CMP_W  = (CNT_W > CHOICE_W - 1) ? CNT_W : CHOICE_W - 1;
	localparam int EXT_W  = (IDX_W > CELL_W) ? IDX_W : CELL_W;
	localparam int DIV_L  = $clog2(GRID_COLUMNS);
	localparam int DIV_S  = IDX_W + DIV_L;
	localparam int DIV_M  = ((1 << DIV_S) + GRID_COLUMNS - 1) / GRID_COLUMNS;
	localparam int PROD_W = IDX_W + DIV_S + 1;

	localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(GRID_CELLS);
	localparam logic [METRE_W-1:0] M_OFFSET  = METRE_W'(CELL_OFFSET_M);
	localparam logic [METRE_W-1:0] M_PITCH   = METRE_W'(CELL_PITCH_M);
	localparam logic [METRE_W-1:0] M_ROWSTEP = METRE_W'(CELL_PITCH_M * GRID_COLUMNS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PICK,
		S_SHIFT,
		S_COORD,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   lw_q;
	logic [IDX_W-1:0]   sel_q;
	logic [IDX_W-1:0]   cell_q;
	logic [IDX_W-1:0]   row_q;
	logic               out_valid_q;
	logic [CELL_W-1:0]  cell_index_q;
	logic [METRE_W-1:0] x_metres_q;
	logic [METRE_W-1:0] y_metres_q;

	logic [IDX_W-1:0] mem [GRID_CELLS];
	logic [IDX_W-1:0] rdata_s1;
	logic [IDX_W-1:0] rd_addr_s1;

	logic               in_xfer;
	logic [CNT_W-1:0]   eff_cnt;
	logic [CNT_W-1:0]   eff_pos;
	logic [CNT_W-1:0]   eff_lw;
	logic               choice_pos;
	logic [CMP_W-1:0]   choice_ext;
	logic [IDX_W-1:0]   sel_c;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   map_val;
	logic [CNT_W-1:0]   next_rd;
	logic               more_shift;
	logic [PROD_W-1:0]  row_prod;
	logic [EXT_W-1:0]   cell_ext;
	logic [METRE_W-1:0] x_c;
	logic [METRE_W-1:0] y_c;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign cell_index = cell_index_q;
	assign x_metres   = x_metres_q;
	assign y_metres   = y_metres_q;

	// start flag restarts the layout ahead of the item itself
	assign eff_cnt = start_of_layout ? CNT_FULL : cnt_q;
	assign eff_pos = start_of_layout ? '0 : pos_q;
	assign eff_lw  = start_of_layout ? CNT_FULL : lw_q;

	assign choice_pos = !choice[CHOICE_W-1] && (choice != '0);
	assign choice_ext = CMP_W'(choice[CHOICE_W-2:0]);

	always_comb begin
		if (choice_pos && (choice_ext <= CMP_W'(eff_cnt))) begin
			sel_c = IDX_W'(choice_ext - CMP_W'(1));
		end else begin
			sel_c = IDX_W'(eff_cnt - CNT_W'(1));
		end
	end

	// entries below the low-water mark were never rewritten and still hold their index
	assign map_val    = (CNT_W'(rd_addr_s1) < lw_q) ? rd_addr_s1 : rdata_s1;
	assign next_rd    = CNT_W'(rd_addr_s1) + CNT_W'(1);
	assign more_shift = next_rd < cnt_q;
	assign wr_addr    = rd_addr_s1 - IDX_W'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sel_c;
		wr_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				rd_en = in_xfer && mode_q && (eff_pos != CNT_FULL) && (eff_cnt != '0);
			end
			S_PICK: begin
				rd_en   = more_shift;
				rd_addr = IDX_W'(next_rd);
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				rd_en   = more_shift;
				rd_addr = IDX_W'(next_rd);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= map_val;
		end
		if (rd_en) begin
			rdata_s1   <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	assign row_prod = PROD_W'(cell_q) * PROD_W'(DIV_M);
	assign cell_ext = EXT_W'(cell_q);
	assign x_c = M_OFFSET + M_PITCH * METRE_W'(cell_q) - M_ROWSTEP * METRE_W'(row_q);
	assign y_c = M_OFFSET + M_PITCH * METRE_W'(row_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sel_q  <= sel_c;
			cell_q <= IDX_W'(eff_pos);
		end
		if (state_q == S_PICK) begin
			cell_q <= map_val;
		end
		if (state_q == S_COORD) begin
			row_q <= IDX_W'(row_prod >> DIV_S);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= 1'b0;
			cnt_q        <= CNT_FULL;
			pos_q        <= '0;
			lw_q         <= CNT_FULL;
			out_valid_q  <= 1'b0;
			cell_index_q <= '0;
			x_metres_q   <= '0;
			y_metres_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q <= eff_cnt;
						lw_q  <= eff_lw;
						if (eff_pos != CNT_FULL) begin
							pos_q <= eff_pos + CNT_W'(1);
							if (!mode_q) begin
								if (choice_pos) begin
									state_q <= S_COORD;
								end
							end else if (eff_cnt != '0) begin
								state_q <= S_PICK;
							end
						end else begin
							pos_q <= eff_pos;
						end
					end
				end
				S_PICK, S_SHIFT: begin
					if (more_shift) begin
						state_q <= S_SHIFT;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						if (CNT_W'(sel_q) < lw_q) begin
							lw_q <= CNT_W'(sel_q);
						end
						state_q <= S_COORD;
					end
				end
				S_COORD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						cell_index_q <= cell_ext[CELL_W-1:0];
						x_metres_q   <= x_c;
						y_metres_q   <= y_c;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/glsd_checker.sv]
// Port-level checks for the grid layout selection decoder.
// Depends on glsd_pkg; bound to grid_layout_selection_decoder_top.
module glsd_checker
	import glsd_pkg::*;
#(
	parameter int GRID_CELLS   = GRID_CELLS_DEF,
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [CELL_W-1:0]          cell_index,
	input logic [METRE_W-1:0]         x_metres,
	input logic [METRE_W-1:0]         y_metres
);

	localparam bit RANGE_CHECK = (GRID_CELLS <= (1 << CELL_W)) && (GRID_COLUMNS > 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_index)
			&& $stable(x_metres) && $stable(y_metres))
		else $error("stalled result changed");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && RANGE_CHECK |-> (int'(cell_index) < GRID_CELLS))
		else $error("cell index beyond grid");

	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_metres[2:0] == 3'b100) && (y_metres[2:0] == 3'b100))
		else $error("coordinate not on a cell centre");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input side was open");

endmodule

bind grid_layout_selection_decoder_top glsd_checker #(
	.GRID_CELLS  (GRID_CELLS),
	.GRID_COLUMNS(GRID_COLUMNS)
) u_glsd_checker (.*);
